FILE: rtl/core/scle_pkg.sv
// Shared types, constants and keymap tables for the scancode line editor.
`default_nettype none
package scle_pkg;

    // Scancodes of the shift keys
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam int         MAP_SIZE        = 58;

    // ASCII codes the editor reacts to
    localparam logic [6:0] CH_BS         = 7'h08;
    localparam logic [6:0] CH_LF         = 7'h0A;
    localparam logic [6:0] CH_SPACE      = 7'h20;
    localparam logic [6:0] CH_PRINT_LAST = 7'h7E;

    // Line buffer geometry
    localparam int         MAX_LINE      = 256;
    localparam int         LIMIT_W       = 9;
    localparam int         INDEX_W       = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP   =
        (MAX_LINE < 256) ? LIMIT_W'(MAX_LINE) : 9'd256;

    // Queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_PRINT = 2'd0,
        OP_BKSP  = 2'd1,
        OP_ENTER = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] ch;
    } qentry_t;

    // US layout, unshifted
    localparam logic [6:0] PLAIN_MAP [MAP_SIZE] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    // US layout, shifted
    localparam logic [6:0] SHIFT_MAP [MAP_SIZE] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

endpackage
`default_nettype wire

FILE: rtl/core/scle_scan_if.sv
// Input channel: one raw scancode per transaction.
`default_nettype none
interface scle_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/scle_echo_if.sv
// Output channel: one echo/store result per transaction.
`default_nettype none
interface scle_echo_if;
    logic       valid;
    logic       ready;
    logic [6:0] echo_char;
    logic       store_en;
    logic [7:0] store_index;
    logic [6:0] store_byte;
    logic       line_done;
    logic       last;

    modport source (output valid, output echo_char, output store_en, output store_index,
                    output store_byte, output line_done, output last, input ready);
    modport sink   (input valid, input echo_char, input store_en, input store_index,
                    input store_byte, input line_done, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/scle_front.sv
// Front end: tracks shift, translates scancodes and classifies edit operations.
`default_nettype none
module scle_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    scle_scan_if.sink          scan,
    input  wire logic          q_full,
    output logic               q_push,
    output scle_pkg::qentry_t  q_entry
);

    logic       shift_reg;
    logic       shift_next;
    logic       accept;
    logic [6:0] ch;
    logic       is_map;

    assign scan.ready = !q_full;
    assign accept     = scan.valid && scan.ready;
    assign is_map     = (scan.scan_byte < 8'(scle_pkg::MAP_SIZE));

    // Translate through the plain or shifted keymap
    assign ch = shift_reg ? scle_pkg::SHIFT_MAP[scan.scan_byte[5:0]]
                          : scle_pkg::PLAIN_MAP[scan.scan_byte[5:0]];

    // Classify the transaction
    always_comb
    begin
        shift_next  = shift_reg;
        q_push      = 1'b0;
        q_entry.op  = scle_pkg::OP_PRINT;
        q_entry.ch  = ch;
        if (accept)
        begin
            priority if (scan.scan_byte == scle_pkg::SC_LSHIFT_MAKE ||
                         scan.scan_byte == scle_pkg::SC_RSHIFT_MAKE)
            begin
                shift_next = 1'b1;
            end
            else if (scan.scan_byte == scle_pkg::SC_LSHIFT_BREAK ||
                     scan.scan_byte == scle_pkg::SC_RSHIFT_BREAK)
            begin
                shift_next = 1'b0;
            end
            else if (is_map)
            begin
                priority if (ch == scle_pkg::CH_LF)
                begin
                    q_push     = 1'b1;
                    q_entry.op = scle_pkg::OP_ENTER;
                end
                else if (ch == scle_pkg::CH_BS)
                begin
                    q_push     = 1'b1;
                    q_entry.op = scle_pkg::OP_BKSP;
                end
                else if (ch >= scle_pkg::CH_SPACE && ch <= scle_pkg::CH_PRINT_LAST)
                begin
                    q_push     = 1'b1;
                    q_entry.op = scle_pkg::OP_PRINT;
                end
                else
                begin
                    q_push = 1'b0;
                end
            end
            else
            begin
                shift_next = shift_reg;
            end
        end
    end

    // Hold the shift flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/scle_queue.sv
// Short FIFO of classified operations between front and back end.
`default_nettype none
module scle_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire scle_pkg::qentry_t  push_entry,
    output logic                    full,
    input  wire logic               pop,
    output logic                    head_valid,
    output scle_pkg::qentry_t       head
);

    localparam int PTR_W = (scle_pkg::QUEUE_DEPTH > 1) ? $clog2(scle_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(scle_pkg::QUEUE_DEPTH + 1);

    scle_pkg::qentry_t entry_reg [scle_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_W'(scle_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(scle_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(scle_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/scle_back.sv
// Back end: applies edit operations to the write index and emits echo results.
`default_nettype none
module scle_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [scle_pkg::LIMIT_W-1:0]    line_limit,
    input  wire logic                            head_valid,
    input  wire scle_pkg::qentry_t               head,
    output logic                                 pop,
    scle_echo_if.source                          echo
);

    typedef enum logic [2:0] {
        BS_FIRST = 3'b001,
        BS_SPACE = 3'b010,
        BS_LAST  = 3'b100
    } bs_state_t;

    bs_state_t                        bs_reg, bs_next;
    logic [scle_pkg::INDEX_W-1:0]     idx_reg, idx_next;
    logic [scle_pkg::LIMIT_W-1:0]     lim_eff;
    logic                             fits;
    logic                             can_load;
    logic                             load;

    logic                             valid_reg, valid_next;
    logic [6:0]                       echo_char_reg, echo_char_next;
    logic                             store_en_reg, store_en_next;
    logic [7:0]                       store_index_reg, store_index_next;
    logic [6:0]                       store_byte_reg, store_byte_next;
    logic                             line_done_reg, line_done_next;
    logic                             last_reg, last_next;

    // Clamp the limit and check for room
    assign lim_eff  = (line_limit > scle_pkg::LIMIT_CAP) ? scle_pkg::LIMIT_CAP : line_limit;
    assign fits     = (lim_eff != '0) &&
                      (({1'b0, idx_reg} + scle_pkg::LIMIT_W'(1)) < lim_eff);
    assign can_load = !valid_reg || echo.ready;

    // Execute the operation at the queue head
    always_comb
    begin
        pop              = 1'b0;
        load             = 1'b0;
        idx_next         = idx_reg;
        bs_next          = bs_reg;
        echo_char_next   = echo_char_reg;
        store_en_next    = 1'b0;
        store_index_next = '0;
        store_byte_next  = '0;
        line_done_next   = 1'b0;
        last_next        = 1'b1;
        if (head_valid)
        begin
            unique case (head.op)
                scle_pkg::OP_PRINT:
                begin
                    if (!fits)
                    begin
                        pop = 1'b1;
                    end
                    else if (can_load)
                    begin
                        pop              = 1'b1;
                        load             = 1'b1;
                        echo_char_next   = head.ch;
                        store_en_next    = 1'b1;
                        store_index_next = idx_reg;
                        store_byte_next  = head.ch;
                        idx_next         = idx_reg + 1'b1;
                    end
                end
                scle_pkg::OP_ENTER:
                begin
                    if (can_load)
                    begin
                        pop              = 1'b1;
                        load             = 1'b1;
                        echo_char_next   = scle_pkg::CH_LF;
                        store_en_next    = 1'b1;
                        store_index_next = idx_reg;
                        line_done_next   = 1'b1;
                        idx_next         = '0;
                    end
                end
                scle_pkg::OP_BKSP:
                begin
                    if (bs_reg == BS_FIRST && idx_reg == '0)
                    begin
                        pop = 1'b1;
                    end
                    else if (can_load)
                    begin
                        load = 1'b1;
                        unique case (bs_reg)
                            BS_FIRST:
                            begin
                                echo_char_next = scle_pkg::CH_BS;
                                last_next      = 1'b0;
                                idx_next       = idx_reg - 1'b1;
                                bs_next        = BS_SPACE;
                            end
                            BS_SPACE:
                            begin
                                echo_char_next = scle_pkg::CH_SPACE;
                                last_next      = 1'b0;
                                bs_next        = BS_LAST;
                            end
                            BS_LAST:
                            begin
                                echo_char_next = scle_pkg::CH_BS;
                                pop            = 1'b1;
                                bs_next        = BS_FIRST;
                            end
                            default:
                            begin
                                load    = 1'b0;
                                bs_next = BS_FIRST;
                            end
                        endcase
                    end
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    assign valid_next = load ? 1'b1 : (echo.ready ? 1'b0 : valid_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            bs_reg    <= BS_FIRST;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            bs_reg    <= bs_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            echo_char_reg   <= echo_char_next;
            store_en_reg    <= store_en_next;
            store_index_reg <= store_index_next;
            store_byte_reg  <= store_byte_next;
            line_done_reg   <= line_done_next;
            last_reg        <= last_next;
        end
    end

    assign echo.valid       = valid_reg;
    assign echo.echo_char   = echo_char_reg;
    assign echo.store_en    = store_en_reg;
    assign echo.store_index = store_index_reg;
    assign echo.store_byte  = store_byte_reg;
    assign echo.line_done   = line_done_reg;
    assign echo.last        = last_reg;

endmodule
`default_nettype wire

FILE: rtl/core/scancode_line_editor_top.sv
// An accepted scancode is registered in the queue entry, then in the back end's output register.
// Throughput: one scancode per cycle for shift, ignored, printable and Enter codes while
// the queue is not full; a backspace occupies the back end for three echo results from its
// single output register. A two-entry queue decouples scancode intake from that.
// Reset: shift released, write index 0, line limit 256, queue and output empty.
`default_nettype none
module scancode_line_editor_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    scle_scan_if.sink                          scan,
    scle_echo_if.source                        echo,
    input  wire logic                          cfg_we,
    input  wire logic [scle_pkg::LIMIT_W-1:0]  cfg_data
);

    logic [scle_pkg::LIMIT_W-1:0] line_limit_reg;
    logic [scle_pkg::LIMIT_W-1:0] line_limit_next;
    logic                         q_push;
    scle_pkg::qentry_t            q_entry;
    logic                         q_full;
    logic                         q_pop;
    logic                         q_valid;
    scle_pkg::qentry_t            q_head;

    // Hold the line limit register
    assign line_limit_next = cfg_we ? cfg_data : line_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= scle_pkg::LIMIT_RESET;
        end
        else
        begin
            line_limit_reg <= line_limit_next;
        end
    end

    scle_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan    (scan),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    scle_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    scle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_limit (line_limit_reg),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .echo       (echo)
    );

    // A stored character is the echoed one, except the terminator
    assert property (@(posedge clk) disable iff (!rst_n)
        echo.valid && echo.store_en && !echo.line_done |-> echo.store_byte == echo.echo_char)
        else $error("stored byte differs from echoed character");

    // Enter stores a terminator and closes the transaction group
    assert property (@(posedge clk) disable iff (!rst_n)
        echo.valid && echo.line_done |->
            echo.store_en && echo.last && echo.store_byte == 7'd0 &&
            echo.echo_char == scle_pkg::CH_LF)
        else $error("line done result malformed");

    // Only backspace echoes come in groups, and they store nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        echo.valid && !echo.last |->
            !echo.store_en && (echo.echo_char == scle_pkg::CH_BS ||
                               echo.echo_char == scle_pkg::CH_SPACE))
        else $error("non-final result is not a backspace echo");

    // A result taken mid-backspace is followed by the next one of the group
    assert property (@(posedge clk) disable iff (!rst_n)
        echo.valid && echo.ready && !echo.last |=> echo.valid)
        else $error("backspace sequence broken");

endmodule
`default_nettype wire

FILE: test/line_echo_checker.sv
// Checker: predicts echo/store results from observed scancode transactions and scores them.
module line_echo_checker
    import scle_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    scle_scan_if               scan,
    scle_echo_if               echo,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_data,
    output int                 mismatch_count,
    output int                 echoes_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0]         echo_char;
        logic               store_en;
        logic [INDEX_W-1:0] store_index;
        logic [6:0]         store_byte;
        logic               line_done;
        logic               last;
    } echo_t;

    // US keymap, independent of the design's tables
    localparam logic [7:0] KEYS_PLAIN [MAP_SIZE] = '{
        8'h00, 8'h1B, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=",
        8'h08, 8'h09, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]",
        8'h0A, 8'h00, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h27, 8'h60,
        8'h00, 8'h5C, "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'h00,
        "*", 8'h00, " "
    };
    localparam logic [7:0] KEYS_SHIFTED [MAP_SIZE] = '{
        8'h00, 8'h1B, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+",
        8'h08, 8'h09, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}",
        8'h0A, 8'h00, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h22, 8'h7E,
        8'h00, "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'h00,
        "*", 8'h00, " "
    };

    echo_t              pending_echoes [$];
    logic               shift_down;
    logic [INDEX_W-1:0] cursor;
    logic [LIMIT_W-1:0] limit_reg;
    int                 result_no;

    function automatic echo_t make_echo(input logic [6:0] ch, input logic en,
                                        input logic [INDEX_W-1:0] idx,
                                        input logic [6:0] stored, input logic done,
                                        input logic fin);
        echo_t e;
        e.echo_char   = ch;
        e.store_en    = en;
        e.store_index = idx;
        e.store_byte  = stored;
        e.line_done   = done;
        e.last        = fin;
        return e;
    endfunction

    // Advance the line state by one scancode and queue the results it causes
    task automatic apply_scancode(input logic [7:0] code);
        logic [7:0] ch;
        int         room;
        if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
            shift_down = 1'b1;
        end
        else if (code == SC_LSHIFT_BREAK || code == SC_RSHIFT_BREAK) begin
            shift_down = 1'b0;
        end
        else if (code < MAP_SIZE) begin
            ch   = shift_down ? KEYS_SHIFTED[code] : KEYS_PLAIN[code];
            room = int'(limit_reg);
            if (room > 256) room = 256;
            if (room > MAX_LINE) room = MAX_LINE;
            if (ch == CH_LF) begin
                pending_echoes.push_back(make_echo(CH_LF, 1'b1, cursor, 7'd0, 1'b1, 1'b1));
                cursor = '0;
            end
            else if (ch == CH_BS) begin
                if (cursor != 0) begin
                    cursor = cursor - 1'b1;
                    pending_echoes.push_back(make_echo(CH_BS, 1'b0, '0, 7'd0, 1'b0, 1'b0));
                    pending_echoes.push_back(make_echo(CH_SPACE, 1'b0, '0, 7'd0, 1'b0, 1'b0));
                    pending_echoes.push_back(make_echo(CH_BS, 1'b0, '0, 7'd0, 1'b0, 1'b1));
                end
            end
            else if (ch >= CH_SPACE && ch <= CH_PRINT_LAST) begin
                if (room != 0 && int'(cursor) < room - 1) begin
                    pending_echoes.push_back(make_echo(ch[6:0], 1'b1, cursor, ch[6:0],
                                                       1'b0, 1'b1));
                    cursor = cursor + 1'b1;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] echo result %0d: %s = %0d, predicted %0d",
                 $time, result_no, what, got, want);
        mismatch_count++;
    endtask

    // Compare one accepted result against the oldest prediction
    task automatic check_echo();
        echo_t want;
        result_no++;
        if (pending_echoes.size() == 0) begin
            report_mismatch("unpredicted result, echo_char", echo.echo_char, -1);
        end
        else begin
            want = pending_echoes.pop_front();
            if (echo.echo_char !== want.echo_char)
                report_mismatch("echo_char", echo.echo_char, want.echo_char);
            if (echo.store_en !== want.store_en)
                report_mismatch("store_en", echo.store_en, want.store_en);
            if (echo.store_index !== want.store_index)
                report_mismatch("store_index", echo.store_index, want.store_index);
            if (echo.store_byte !== want.store_byte)
                report_mismatch("store_byte", echo.store_byte, want.store_byte);
            if (echo.line_done !== want.line_done)
                report_mismatch("line_done", echo.line_done, want.line_done);
            if (echo.last !== want.last)
                report_mismatch("last", echo.last, want.last);
        end
    endtask

    // Track register writes, scancode transactions and result transactions
    always @(posedge clk) begin
        if (!rst_n) begin
            shift_down     = 1'b0;
            cursor         = '0;
            limit_reg      = LIMIT_RESET;
            result_no      = 0;
            mismatch_count = 0;
            pending_echoes.delete();
        end
        else begin
            if (cfg_we)
                limit_reg = cfg_data;
            if (scan.valid && scan.ready)
                apply_scancode(scan.scan_byte);
            if (echo.valid && echo.ready)
                check_echo();
        end
        echoes_owed = pending_echoes.size();
    end

endmodule

FILE: test/testbench.sv
// Top of the line editor testbench: clock, reset, scancode stimulus, result drain, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import scle_pkg::*;

    // Scancodes of keys with special meaning to the editor
    localparam logic [7:0] SC_ESC   = 8'h01;
    localparam logic [7:0] SC_BKSP  = 8'h0E;
    localparam logic [7:0] SC_TAB   = 8'h0F;
    localparam logic [7:0] SC_ENTER = 8'h1C;
    localparam logic [7:0] SC_LCTRL = 8'h1D;
    localparam logic [7:0] SC_LALT  = 8'h38;

    localparam int ITEM_TARGET = 430;
    localparam int PHASE_ITEMS = 14;
    localparam int CHOKE_CYCLES = 90;

    localparam logic [7:0] OPENING_CODES [25] = '{
        8'h1E, SC_LSHIFT_MAKE, 8'h1E, 8'h02, 8'h29, SC_LSHIFT_BREAK, 8'h29, 8'h39,
        8'h37, SC_BKSP, SC_RSHIFT_MAKE, 8'h2B, SC_RSHIFT_BREAK, SC_ESC, SC_TAB,
        8'h00, SC_LCTRL, 8'h3A, 8'hFF, 8'h80, 8'h9E, SC_ENTER, SC_BKSP, SC_ENTER, 8'h35
    };
    localparam logic [LIMIT_W-1:0] PHASE_LIMITS [8] = '{
        9'd0, 9'd1, 9'd2, 9'd3, 9'd5, 9'd255, 9'd256, 9'd300
    };

    typedef enum int {
        DRAIN_FREE,
        DRAIN_COIN,
        DRAIN_SLOW,
        DRAIN_ALTERNATE
    } drain_mode_t;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_data;
    int                 mismatch_count;
    int                 echoes_owed;
    int                 sent_items = 0;
    int                 burst_left = 0;
    int                 choke_req  = 0;
    bit                 shift_down = 1'b0;

    scle_scan_if scan_ch ();
    scle_echo_if echo_ch ();

    scancode_line_editor_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .scan     (scan_ch),
        .echo     (echo_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    line_echo_checker score (
        .clk            (clk),
        .rst_n          (rst_n),
        .scan           (scan_ch),
        .echo           (echo_ch),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .echoes_owed    (echoes_owed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Offer one scancode, inserting a random gap between bursts, and hold until accepted
    task automatic send_code(input logic [7:0] code);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                scan_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        scan_ch.valid     <= 1'b1;
        scan_ch.scan_byte <= code;
        do @(posedge clk); while (!scan_ch.ready);
    endtask

    function automatic logic [7:0] printable_code();
        logic [7:0] code;
        do code = 8'($urandom_range(2, 57));
        while (code == SC_BKSP || code == SC_TAB || code == SC_ENTER || code == SC_LCTRL ||
               code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE || code == SC_LALT);
        return code;
    endfunction

    // Type a line of keys with shift changes, erases and some noise (printable keys only when plain), then maybe Enter
    task automatic type_line(input int length, input bit finish, input bit plain);
        int pick;
        for (int i = 0; i < length; i++)
        begin
            pick = plain ? 99 : $urandom_range(0, 99);
            if (pick < 8)
            begin
                if (shift_down)
                    send_code($urandom_range(0, 1) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK);
                else
                    send_code($urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE);
                shift_down = !shift_down;
                sent_items++;
            end
            else if (pick < 16)
            begin
                send_code(SC_BKSP);
                sent_items++;
            end
            else if (pick < 20)
            begin
                send_code(8'($urandom_range(0, 255)));
                sent_items++;
            end
            else
            begin
                send_code(printable_code());
                sent_items++;
            end
        end
        if (finish)
        begin
            send_code(SC_ENTER);
            sent_items++;
        end
    endtask

    // Drain the block, let dropped codes clear the pipeline, then write the limit
    task automatic write_line_limit(input logic [LIMIT_W-1:0] value);
        scan_ch.valid <= 1'b0;
        @(posedge clk);
        while (echoes_owed != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input int quota);
        int phase_start;
        int len;
        phase_start = sent_items;
        while (sent_items - phase_start < quota)
        begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 8);
            type_line(len, $urandom_range(0, 9) != 0, 1'b0);
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        scan_ch.valid     <= 1'b0;
        scan_ch.scan_byte <= 8'h00;
        cfg_we            <= 1'b0;
        cfg_data          <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (OPENING_CODES[i])
        begin
            send_code(OPENING_CODES[i]);
            sent_items++;
        end

        // Overfill the buffer at an over-range limit while the drain holds off
        write_line_limit(9'd511);
        choke_req++;
        type_line(258, 1'b1, 1'b1);
        type_line(6, 1'b1, 1'b0);

        foreach (PHASE_LIMITS[i])
        begin
            write_line_limit(PHASE_LIMITS[i]);
            if (i == 3)
                choke_req++;
            run_phase(PHASE_ITEMS);
        end
        while (sent_items < ITEM_TARGET)
        begin
            write_line_limit(9'($urandom_range(1, 256)));
            run_phase(PHASE_ITEMS);
        end

        scan_ch.valid <= 1'b0;
        @(posedge clk);
        while (echoes_owed != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Drain results with changing stall patterns and occasional long hold-offs
    initial
    begin : echo_drain
        drain_mode_t mode;
        int          mode_left;
        int          hold_left;
        int          choke_seen;
        bit          phase_bit;
        mode       = DRAIN_FREE;
        mode_left  = 0;
        hold_left  = 0;
        choke_seen = 0;
        phase_bit  = 1'b0;
        echo_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (choke_req != choke_seen)
            begin
                choke_seen = choke_req;
                hold_left  = CHOKE_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = drain_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 60);
            end
            mode_left--;
            phase_bit = !phase_bit;
            if (hold_left > 0)
            begin
                hold_left--;
                echo_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    DRAIN_FREE:      echo_ch.ready <= 1'b1;
                    DRAIN_COIN:      echo_ch.ready <= 1'($urandom_range(0, 1));
                    DRAIN_SLOW:      echo_ch.ready <= ($urandom_range(0, 3) == 0);
                    DRAIN_ALTERNATE: echo_ch.ready <= phase_bit;
                    default:         echo_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
